// ----- src/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types, constants and codes of the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int MAX_PAGES = 4096;
    localparam int IDX_W     = $clog2(MAX_PAGES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SLACK_W   = 8;
    localparam int FLAG_W    = 4;
    localparam int QUOTA_W   = CNT_W + 2;

    localparam logic [FLAG_W-1:0] FL_ALLOC = 4'b0001;
    localparam logic [FLAG_W-1:0] FL_KERN  = 4'b0010;
    localparam logic [FLAG_W-1:0] FL_PIN   = 4'b0100;
    localparam logic [FLAG_W-1:0] FL_CONT  = 4'b1000;

    localparam logic CFG_NUM_PAGES = 1'b0;
    localparam logic CFG_MIN_SLACK = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_QUOTA   = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_EVICT   = 3'd3,
        ST_BAD     = 3'd4,
        ST_BUSY    = 3'd5,
        ST_NOTPIN  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        FN_ALLOC_USER = 3'd0,
        FN_ALLOC_KERN = 3'd1,
        FN_FREE       = 3'd2,
        FN_PIN        = 3'd3,
        FN_UNPIN      = 3'd4
    } t_func;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_EV   = 6'b001000,
        S_WR   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        M_SCAN = 3'd0,
        M_WIN  = 3'd1,
        M_FCHK = 3'd2,
        M_FWR  = 3'd3,
        M_PIN  = 3'd4
    } t_mode;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [FLAG_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr_a;
        logic [IDX_W-1:0]  raddr_b;
    } t_mem_req;

    typedef struct packed {
        logic [CNT_W-1:0]   frames;
        logic [SLACK_W-1:0] slack;
    } t_cfg;

endpackage

// ----- src/pfa_in_if.sv -----
// ----------------------------------------------------------------------------
// pfa_in_if
// request channel: valid, ready and one request
// ----------------------------------------------------------------------------
interface pfa_in_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               func;
    logic [pfa_pkg::IDX_W-1:0] page_index;
    logic [pfa_pkg::CNT_W-1:0] page_count;
    logic                     is_kernel;

    modport source (output valid, func, page_index, page_count, is_kernel, input ready);
    modport sink   (input valid, func, page_index, page_count, is_kernel, output ready);
endinterface

// ----- src/pfa_out_if.sv -----
// ----------------------------------------------------------------------------
// pfa_out_if
// result channel: valid, ready and one result
// ----------------------------------------------------------------------------
interface pfa_out_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               status;
    logic [pfa_pkg::IDX_W-1:0] result_page;
    logic [pfa_pkg::CNT_W-1:0] result_count;
    logic [pfa_pkg::CNT_W-1:0] free_pages;
    logic [pfa_pkg::CNT_W-1:0] kernel_pages;
    logic [pfa_pkg::CNT_W-1:0] user_pages;

    modport source (output valid, status, result_page, result_count, free_pages,
                    kernel_pages, user_pages, input ready);
    modport sink   (input valid, status, result_page, result_count, free_pages,
                    kernel_pages, user_pages, output ready);
endinterface

// ----- src/pfa_flag_store.sv -----
// ----------------------------------------------------------------------------
// pfa_flag_store
// frame flag memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
module pfa_flag_store (
    input  logic                             i_clk,
    input  pfa_pkg::t_mem_req                i_req,
    output logic [pfa_pkg::FLAG_W-1:0]       o_rd_a,
    output logic [pfa_pkg::FLAG_W-1:0]       o_rd_b
);

    logic [pfa_pkg::FLAG_W-1:0] r_mem [pfa_pkg::MAX_PAGES];
    logic [pfa_pkg::FLAG_W-1:0] r_rd_a;
    logic [pfa_pkg::FLAG_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_a <= r_mem[i_req.raddr_a];
        r_rd_b <= r_mem[i_req.raddr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ----- src/pfa_seq.sv -----
// ----------------------------------------------------------------------------
// pfa_seq
// sequencer: walks the flag store one frame per read/evaluate pair
// ----------------------------------------------------------------------------
module pfa_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pfa_pkg::t_cfg              i_cfg,
    pfa_in_if.sink                     i_in,
    pfa_out_if.source                  o_out,
    output pfa_pkg::t_mem_req          o_mem,
    input  logic [pfa_pkg::FLAG_W-1:0] i_rd_a,
    input  logic [pfa_pkg::FLAG_W-1:0] i_rd_b
);

    localparam int IW = pfa_pkg::IDX_W;
    localparam int CW = pfa_pkg::CNT_W;
    localparam int QW = pfa_pkg::QUOTA_W;

    pfa_pkg::t_state  r_state, n_state;
    pfa_pkg::t_mode   r_mode, n_mode;
    pfa_pkg::t_status r_status, n_status;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_base, n_base;
    logic [IW-1:0] r_best, n_best;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_rpage, n_rpage;
    logic [CW-1:0] r_bad, n_bad;
    logic [CW-1:0] r_bestbad, n_bestbad;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_rcount, n_rcount;
    logic [CW-1:0] r_ktot, n_ktot;
    logic [CW-1:0] r_utot, n_utot;
    logic          r_have_base, n_have_base;
    logic          r_have_best, n_have_best;
    logic          r_kern, n_kern;
    logic          r_pin_op, n_pin_op;

    logic [IW-1:0] last_frame;
    logic [QW-1:0] quota_sum;
    logic          no_frames;
    logic [CW-1:0] bad_inc;
    logic [CW:0]   used;
    logic [IW-1:0] span;

    assign no_frames  = (i_cfg.frames == '0);
    assign last_frame = IW'(i_cfg.frames - CW'(1));
    assign used       = {1'b0, r_ktot} + {1'b0, r_utot};
    assign span       = r_i - r_base;
    assign bad_inc    = r_bad + CW'(i_rd_a[0]);

    always_comb begin
        logic [CW-1:0] k;
        logic          single;
        logic          upd;
        k      = (i_in.func == pfa_pkg::FN_ALLOC_KERN && i_in.page_count > CW'(1))
                 ? i_in.page_count : CW'(1);
        single = (i_in.func == pfa_pkg::FN_ALLOC_USER) ||
                 (i_in.func == pfa_pkg::FN_ALLOC_KERN && i_in.page_count <= CW'(1));
        upd    = 1'b0;
        quota_sum = QW'(r_ktot) + QW'(k) + QW'(i_cfg.slack);

        n_state = r_state;   n_mode = r_mode;     n_status = r_status;
        n_i = r_i;           n_base = r_base;     n_best = r_best;
        n_idx = r_idx;       n_rpage = r_rpage;   n_bad = r_bad;
        n_bestbad = r_bestbad; n_cnt = r_cnt;     n_left = r_left;
        n_len = r_len;       n_rcount = r_rcount; n_ktot = r_ktot;
        n_utot = r_utot;     n_have_base = r_have_base;
        n_have_best = r_have_best; n_kern = r_kern; n_pin_op = r_pin_op;

        o_mem = '0;
        o_mem.raddr_a = r_i;
        o_mem.raddr_b = r_base;

        case (r_state)
            pfa_pkg::S_CLR: begin
                // clearing pass over the whole store
                o_mem.we    = 1'b1;
                o_mem.waddr = r_i;
                o_mem.wdata = '0;
                n_i = r_i + IW'(1);
                if (r_i == '1) begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_status = pfa_pkg::ST_OK;
                    n_rpage  = '0;
                    n_rcount = '0;
                    n_idx    = i_in.page_index;
                    n_cnt    = i_in.page_count;
                    n_kern   = i_in.is_kernel;
                    n_pin_op = (i_in.func == pfa_pkg::FN_PIN);
                    n_state  = pfa_pkg::S_OUT;
                    if (single) begin
                        n_kern = (i_in.func == pfa_pkg::FN_ALLOC_KERN);
                        if (n_kern && quota_sum >= QW'(i_cfg.frames)) begin
                            n_status = pfa_pkg::ST_QUOTA;
                        end else if (no_frames) begin
                            n_status = pfa_pkg::ST_NOSPACE;
                        end else begin
                            n_mode  = pfa_pkg::M_SCAN;
                            n_i     = last_frame;
                            n_state = pfa_pkg::S_RD;
                        end
                    end else if (i_in.func == pfa_pkg::FN_ALLOC_KERN) begin
                        if (quota_sum >= QW'(i_cfg.frames)) begin
                            n_status = pfa_pkg::ST_QUOTA;
                        end else begin
                            n_mode      = pfa_pkg::M_WIN;
                            n_i         = '0;
                            n_base      = '0;
                            n_bad       = '0;
                            n_bestbad   = '0;
                            n_best      = '0;
                            n_have_base = 1'b0;
                            n_have_best = 1'b0;
                            n_state     = pfa_pkg::S_RD;
                        end
                    end else if (i_in.func == pfa_pkg::FN_FREE ||
                                 i_in.func == pfa_pkg::FN_PIN ||
                                 i_in.func == pfa_pkg::FN_UNPIN) begin
                        n_rpage = i_in.page_index;
                        if (CW'(i_in.page_index) >= i_cfg.frames) begin
                            n_status = pfa_pkg::ST_BAD;
                        end else begin
                            n_mode  = (i_in.func == pfa_pkg::FN_FREE)
                                      ? pfa_pkg::M_FCHK : pfa_pkg::M_PIN;
                            n_i     = i_in.page_index;
                            n_len   = '0;
                            n_state = pfa_pkg::S_RD;
                        end
                    end else begin
                        n_status = pfa_pkg::ST_BAD;
                    end
                end
            end
            pfa_pkg::S_RD: begin
                n_state = pfa_pkg::S_EV;
            end
            pfa_pkg::S_EV: begin
                n_state = pfa_pkg::S_RD;
                case (r_mode)
                    pfa_pkg::M_SCAN: begin
                        if ((i_rd_a & (pfa_pkg::FL_ALLOC | pfa_pkg::FL_PIN)) == '0) begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_i;
                            o_mem.wdata = r_kern ? (pfa_pkg::FL_ALLOC | pfa_pkg::FL_KERN)
                                                 : (pfa_pkg::FL_ALLOC | pfa_pkg::FL_PIN);
                            if (r_kern) begin
                                n_ktot = r_ktot + CW'(1);
                            end else begin
                                n_utot = r_utot + CW'(1);
                            end
                            n_rpage = r_i;
                            n_state = pfa_pkg::S_OUT;
                        end else if (r_i == '0) begin
                            n_status = pfa_pkg::ST_NOSPACE;
                            n_state  = pfa_pkg::S_OUT;
                        end else begin
                            n_i = r_i - IW'(1);
                        end
                    end
                    pfa_pkg::M_WIN: begin
                        if ((i_rd_a & (pfa_pkg::FL_PIN | pfa_pkg::FL_KERN)) != '0) begin
                            // pinned or kernel frame breaks the window
                            n_have_base = 1'b0;
                            n_bad       = '0;
                        end else if (!r_have_base) begin
                            n_have_base = 1'b1;
                            n_base      = r_i;
                            n_bad       = bad_inc;
                        end else if ({1'b0, span} >= r_cnt - CW'(1)) begin
                            upd = !r_have_best || (bad_inc < r_bestbad);
                            if (upd) begin
                                n_have_best = 1'b1;
                                n_best      = r_base;
                                n_bestbad   = bad_inc;
                            end
                            n_bad  = (i_rd_b[0] && bad_inc != '0) ? bad_inc - CW'(1)
                                                                 : bad_inc;
                            n_base = r_base + IW'(1);
                        end else begin
                            n_bad = bad_inc;
                        end
                        if (r_i == last_frame) begin
                            n_state = pfa_pkg::S_OUT;
                            if (!n_have_best) begin
                                n_status = pfa_pkg::ST_NOSPACE;
                            end else if (n_bestbad != '0) begin
                                n_status = pfa_pkg::ST_EVICT;
                                n_rpage  = n_best;
                                n_rcount = n_bestbad;
                            end else begin
                                n_rpage = n_best;
                                n_i     = n_best;
                                n_left  = r_cnt;
                                n_state = pfa_pkg::S_WR;
                            end
                        end else begin
                            n_i = r_i + IW'(1);
                        end
                    end
                    pfa_pkg::M_FCHK: begin
                        if (!i_rd_a[0] || (i_rd_a[1] != r_kern) ||
                            (!i_rd_a[1] && !i_rd_a[2])) begin
                            n_status = pfa_pkg::ST_BAD;
                            n_state  = pfa_pkg::S_OUT;
                        end else if (!i_rd_a[3] || CW'(r_i) + CW'(1) >= i_cfg.frames) begin
                            n_len  = r_len + CW'(1);
                            n_left = r_len + CW'(1);
                            n_i    = r_idx;
                            n_mode = pfa_pkg::M_FWR;
                        end else begin
                            n_len = r_len + CW'(1);
                            n_i   = r_i + IW'(1);
                        end
                    end
                    pfa_pkg::M_FWR: begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_i;
                        o_mem.wdata = i_rd_a & pfa_pkg::FL_PIN;
                        if (r_left == CW'(1)) begin
                            if (r_kern) begin
                                n_ktot = (r_ktot > r_len) ? r_ktot - r_len : '0;
                            end else begin
                                n_utot = (r_utot > r_len) ? r_utot - r_len : '0;
                            end
                            n_rcount = r_len;
                            n_state  = pfa_pkg::S_OUT;
                        end else begin
                            n_left = r_left - CW'(1);
                            n_i    = r_i + IW'(1);
                        end
                    end
                    pfa_pkg::M_PIN: begin
                        n_state = pfa_pkg::S_OUT;
                        if (r_pin_op) begin
                            if (i_rd_a[2]) begin
                                n_status = pfa_pkg::ST_BUSY;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_i;
                                o_mem.wdata = i_rd_a | pfa_pkg::FL_PIN;
                            end
                        end else begin
                            if (!i_rd_a[2]) begin
                                n_status = pfa_pkg::ST_NOTPIN;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_i;
                                o_mem.wdata = i_rd_a & ~pfa_pkg::FL_PIN;
                            end
                        end
                    end
                    default: begin
                        n_state = pfa_pkg::S_OUT;
                    end
                endcase
            end
            pfa_pkg::S_WR: begin
                // write the kernel run one frame a cycle
                o_mem.we    = 1'b1;
                o_mem.waddr = r_i;
                o_mem.wdata = pfa_pkg::FL_ALLOC | pfa_pkg::FL_KERN |
                              ((r_left != CW'(1)) ? pfa_pkg::FL_CONT : '0);
                if (r_left == CW'(1)) begin
                    n_ktot  = r_ktot + r_cnt;
                    n_state = pfa_pkg::S_OUT;
                end else begin
                    n_left = r_left - CW'(1);
                    n_i    = r_i + IW'(1);
                end
            end
            pfa_pkg::S_OUT: begin
                if (o_out.ready) begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfa_pkg::S_CLR;
            r_i         <= '0;
            r_ktot      <= '0;
            r_utot      <= '0;
            r_have_base <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_ktot      <= n_ktot;
            r_utot      <= n_utot;
            r_have_base <= n_have_base;
            r_have_best <= n_have_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_status  <= n_status;
        r_base    <= n_base;
        r_best    <= n_best;
        r_idx     <= n_idx;
        r_rpage   <= n_rpage;
        r_bad     <= n_bad;
        r_bestbad <= n_bestbad;
        r_cnt     <= n_cnt;
        r_left    <= n_left;
        r_len     <= n_len;
        r_rcount  <= n_rcount;
        r_kern    <= n_kern;
        r_pin_op  <= n_pin_op;
    end

    assign i_in.ready         = (r_state == pfa_pkg::S_IDLE);
    assign o_out.valid        = (r_state == pfa_pkg::S_OUT);
    assign o_out.status       = r_status;
    assign o_out.result_page  = r_rpage;
    assign o_out.result_count = r_rcount;
    assign o_out.kernel_pages = r_ktot;
    assign o_out.user_pages   = r_utot;
    assign o_out.free_pages   = (used >= {1'b0, i_cfg.frames}) ? '0
                                : CW'({1'b0, i_cfg.frames} - used);

    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("ready and result valid together");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfa_pkg::S_OUT && !o_out.ready) |=>
        (r_state == pfa_pkg::S_OUT && $stable(r_status) && $stable(r_rpage)))
        else $error("pending result changed");

    a_win_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfa_pkg::S_EV && r_mode == pfa_pkg::M_WIN && r_have_base)
        |-> (r_base <= r_i))
        else $error("window base beyond scan position");

    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfa_pkg::S_WR) |-> (r_left != '0))
        else $error("run write with nothing left");

endmodule

// ----- src/page_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator
// physical page frame map with single-page, kernel-run, free and pin requests
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        func, page_index, page_count, is_kernel
//  o_out     out  valid/ready        status, result_page, result_count, counts
//  i_cfg_*   in   write enable only  register index, data
//
//  after reset a clearing pass writes every frame to zero; no request is taken
//  meanwhile; config writes are taken at any time; a frame visit in a search,
//  free or pin is a read and an evaluate state on the flag store; single page:
//  scan down from the last frame; kernel run: window scan of all frames, then
//  run write; free: run check, then its write; pin/unpin: one visit; a result
//  holds until its transfer, and the next request is taken the cycle after
// ----------------------------------------------------------------------------
module page_frame_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pfa_in_if.sink                      i_in,
    pfa_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [pfa_pkg::CNT_W-1:0]   i_cfg_data
);

    pfa_pkg::t_cfg                     cfg;
    pfa_pkg::t_mem_req                 mem_req;
    logic [pfa_pkg::FLAG_W-1:0]        rd_a;
    logic [pfa_pkg::FLAG_W-1:0]        rd_b;
    logic [pfa_pkg::CNT_W-1:0]         r_num_pages;
    logic [pfa_pkg::SLACK_W-1:0]       r_min_slack;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_pages <= pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES);
            r_min_slack <= pfa_pkg::SLACK_W'(8);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pfa_pkg::CFG_NUM_PAGES) begin
                r_num_pages <= i_cfg_data;
            end else begin
                r_min_slack <= i_cfg_data[pfa_pkg::SLACK_W-1:0];
            end
        end
    end

    // frame count clamped to the map depth
    assign cfg.frames = (r_num_pages > pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES))
                        ? pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES) : r_num_pages;
    assign cfg.slack  = r_min_slack;

    pfa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_mem   (mem_req),
        .i_rd_a  (rd_a),
        .i_rd_b  (rd_b)
    );

    pfa_flag_store u_store (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

endmodule
